// ----- rtl/core/sdbd_pkg.sv -----
// shared constants and types for the second derivative estimator
package sdbd_pkg;
  localparam int LANES       = 3;
  localparam int SAMPLE_BITS = 32;
  localparam int TIME_BITS   = 32;
  localparam int OUT_BITS    = 48;
  localparam int DEN_BITS    = 99;   // |f1|<2^32, |f2|<2^33, |f3|<2^33
  localparam int NUM_BITS    = 66;   // 2*num*|v|: 2^34 * 2^32
  localparam int QUO_BITS    = 66;
  localparam int ACC_BITS    = 72;
  localparam int CNT_BITS    = 7;
  localparam int MULA_BITS   = 34;

  typedef struct packed {
    logic                start;
    logic [NUM_BITS-1:0] num;
    logic [DEN_BITS-1:0] den;
  } div_req_t;
endpackage

// ----- rtl/core/sdbd_mul.sv -----
// bit-serial shift-and-add multiplier, one multiplier bit per cycle
module sdbd_mul import sdbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [MULA_BITS-1:0]  a,
  input  logic [DEN_BITS-1:0]   b,
  output logic                  done,
  output logic [DEN_BITS-1:0]   p
);
  logic [MULA_BITS-1:0] a_r, a_nxt;
  logic [DEN_BITS-1:0]  b_r, b_nxt, p_r, p_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    a_nxt = a_r; b_nxt = b_r; p_nxt = p_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      a_nxt = a; b_nxt = b; p_nxt = '0; busy_nxt = 1'b1;
      cnt_nxt = CNT_BITS'(MULA_BITS);
    end else if (busy_r) begin
      if (a_r[0]) p_nxt = p_r + b_r;
      a_nxt = a_r >> 1;
      b_nxt = b_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; p_r <= p_nxt; cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign p    = p_r;
endmodule

// ----- rtl/core/sdbd_div.sv -----
// restoring divider, one quotient bit per cycle
module sdbd_div import sdbd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  div_req_t             req,
  output logic                 done,
  output logic [QUO_BITS-1:0]  quo
);
  logic [NUM_BITS-1:0] n_r, n_nxt;
  logic [DEN_BITS-1:0] d_r, d_nxt;
  logic [DEN_BITS:0]   r_r, r_nxt, sh;
  logic [QUO_BITS-1:0] q_r, q_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    n_nxt = n_r; d_nxt = d_r; r_nxt = r_r; q_nxt = q_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    sh = {r_r[DEN_BITS-1:0], n_r[NUM_BITS-1]};
    if (req.start) begin
      n_nxt = req.num; d_nxt = req.den; r_nxt = '0; q_nxt = '0;
      busy_nxt = 1'b1; cnt_nxt = CNT_BITS'(NUM_BITS);
    end else if (busy_r) begin
      n_nxt = n_r << 1;
      if (sh >= {1'b0, d_r}) begin
        r_nxt = sh - {1'b0, d_r};
        q_nxt = {q_r[QUO_BITS-2:0], 1'b1};
      end else begin
        r_nxt = sh;
        q_nxt = {q_r[QUO_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    n_r <= n_nxt; d_r <= d_nxt; r_r <= r_nxt; q_r <= q_nxt; cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

// ----- rtl/core/second_derivative_backward_diff.sv -----
// top level of the backward-difference second derivative estimator
// usage:
//   in_tdata carries one request: a timestamp and three signed q16.16
//   samples sharing it. out_tdata returns the three saturated 48 bit
//   second derivatives, out_tuser says whether the estimate is valid.
//   the first three requests after reset answer zero with out_tuser low.
// sequencing:
//   one request at a time. a warm-up request goes straight from S_IDLE
//   to S_OUT. a full request runs 15 terms (5 per lane) through one
//   bit-serial multiplier and one restoring divider. a term steps through
//   setup, two products, the quotient and a step state; a term with a
//   zero denominator skips the divider. the next request is taken no
//   sooner than the cycle after the result leaves.
// reset:
//   rst_n low clears history, warm-up count and handshake state.
// stall:
//   the result sits in an output register until taken; in_tready stays
//   low while a request is held or its result waits.
module second_derivative_backward_diff import sdbd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // sample_time, value_x, value_y, value_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // deriv_x, deriv_y, deriv_z
  output logic         out_tuser   // estimate_ready
);
  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0, S_SETUP = 3'd1, S_MUL1 = 3'd2,
                         S_MUL2 = 3'd3, S_DIV = 3'd4, S_NEXT = 3'd5,
                         S_OUT = 3'd6;

  logic [2:0] st_r, st_nxt;
  logic [1:0] warm_r, warm_nxt;
  logic [TIME_BITS-1:0]   pt_r [3];
  logic [SAMPLE_BITS-1:0] ps_r [3][LANES];
  logic [TIME_BITS-1:0]   t_r;
  logic [SAMPLE_BITS-1:0] v_r [LANES];
  logic [1:0] lane_r, lane_nxt;
  logic [2:0] term_r, term_nxt;
  logic signed [ACC_BITS-1:0] acc_r, acc_nxt;
  logic [OUT_BITS-1:0] res_r [LANES];
  logic ready_flag_r;
  logic neg_r, neg_nxt;
  logic [NUM_BITS-1:0] num_r, num_nxt;

  // time differences, taken as unsigned 32 bit then exact signed
  logic [TIME_BITS-1:0] d1, d2, d3;
  logic signed [TIME_BITS+1:0] sd1, sd2, sd3, d31, d12, d23;
  assign d1 = t_r - pt_r[0];
  assign d2 = t_r - pt_r[1];
  assign d3 = t_r - pt_r[2];
  assign sd1 = {2'b00, d1};
  assign sd2 = {2'b00, d2};
  assign sd3 = {2'b00, d3};
  assign d31 = sd3 - sd1;
  assign d12 = sd1 - sd2;
  assign d23 = sd2 - sd3;

  // term selection
  logic signed [TIME_BITS+1:0] f1, f2, f3, nsum;
  logic [SAMPLE_BITS-1:0] sv;
  logic minus;
  always_comb begin
    f1 = sd1; f2 = sd2; f3 = d31; nsum = sd2 + sd3; minus = 1'b0;
    sv = v_r[lane_r];
    case (term_r)
      3'd0: begin f1 = sd1; f2 = sd2; f3 = d31; nsum = sd2 + sd3; end
      3'd1: begin f1 = sd2; f2 = sd3; f3 = d31; nsum = sd1 + sd2; minus = 1'b1; end
      3'd2: begin f1 = sd1; f2 = d12; f3 = d31; nsum = sd2 + sd3; sv = ps_r[0][lane_r]; end
      3'd3: begin f1 = sd2; f2 = d12; f3 = d23; nsum = sd1 + sd3; sv = ps_r[1][lane_r]; end
      3'd4: begin f1 = sd3; f2 = d23; f3 = d31; nsum = sd1 + sd2; sv = ps_r[2][lane_r]; end
      default: ;
    endcase
  end

  function automatic logic [MULA_BITS-1:0] mag34(input logic signed [TIME_BITS+1:0] x);
    mag34 = x[TIME_BITS+1] ? MULA_BITS'(-x) : MULA_BITS'(x);
  endfunction

  logic [SAMPLE_BITS-1:0] vmag;
  assign vmag = sv[SAMPLE_BITS-1] ? -sv : sv;

  // shared serial multiplier
  logic                 m_start, m_done;
  logic [MULA_BITS-1:0] m_a;
  logic [DEN_BITS-1:0]  m_b, m_p;
  sdbd_mul u_mul (.clk, .rst_n, .start(m_start), .a(m_a), .b(m_b),
                  .done(m_done), .p(m_p));

  // shared serial divider
  div_req_t            dreq;
  logic                d_done;
  logic [QUO_BITS-1:0] d_quo;
  sdbd_div u_div (.clk, .rst_n, .req(dreq), .done(d_done), .quo(d_quo));

  logic accept;
  assign in_tready = (st_r == S_IDLE) && !out_tvalid;
  assign accept    = in_tvalid && in_tready;

  logic out_v_r, out_v_nxt;

  always_comb begin
    st_nxt = st_r; warm_nxt = warm_r; lane_nxt = lane_r; term_nxt = term_r;
    acc_nxt = acc_r; neg_nxt = neg_r; num_nxt = num_r;
    out_v_nxt = out_v_r;
    m_start = 1'b0; m_a = '0; m_b = '0;
    dreq = '0;
    if (out_v_r && out_tready) out_v_nxt = 1'b0;
    case (st_r)
      S_IDLE: if (accept) st_nxt = (warm_r == 2'd3) ? S_SETUP : S_OUT;
      S_SETUP: begin
        // first product f1*f2, sign and numerator magnitude noted
        m_start = 1'b1;
        m_a = mag34(f1);
        m_b = DEN_BITS'(mag34(f2));
        neg_nxt = minus ^ f1[TIME_BITS+1] ^ f2[TIME_BITS+1] ^ f3[TIME_BITS+1]
                  ^ sv[SAMPLE_BITS-1];
        // weight sum is never negative and fits 33 bits
        num_nxt = nsum[TIME_BITS:0] * vmag;
        st_nxt = S_MUL1;
      end
      S_MUL1: if (m_done) begin
        m_start = 1'b1; m_a = mag34(f3); m_b = m_p;
        st_nxt = S_MUL2;
      end
      S_MUL2: if (m_done) begin
        if (m_p == '0) st_nxt = S_NEXT;
        else begin
          dreq.start = 1'b1; dreq.num = num_r << 1; dreq.den = m_p;
          st_nxt = S_DIV;
        end
      end
      S_DIV: if (d_done) begin
        acc_nxt = neg_r ? acc_r - ACC_BITS'(d_quo) : acc_r + ACC_BITS'(d_quo);
        st_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (term_r == 3'd4) begin
          term_nxt = '0; acc_nxt = '0;
          if (lane_r == 2'(LANES-1)) begin
            lane_nxt = '0; st_nxt = S_OUT;
          end else begin
            lane_nxt = lane_r + 1'b1; st_nxt = S_SETUP;
          end
        end else begin
          term_nxt = term_r + 1'b1; st_nxt = S_SETUP;
        end
      end
      S_OUT: begin
        out_v_nxt = 1'b1;
        if (warm_r != 2'd3) warm_nxt = warm_r + 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // saturation of the finished lane sum
  logic [OUT_BITS-1:0] sat;
  always_comb begin
    if (acc_r > ACC_BITS'(signed'({1'b0, {(OUT_BITS-1){1'b1}}})))
      sat = {1'b0, {(OUT_BITS-1){1'b1}}};
    else if (acc_r < -(ACC_BITS'(signed'({1'b0, 1'b1, {(OUT_BITS-1){1'b0}}}))))
      sat = {1'b1, {(OUT_BITS-1){1'b0}}};
    else sat = acc_r[OUT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; warm_r <= '0; lane_r <= '0; term_r <= '0;
      acc_r <= '0; out_v_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        pt_r[k] <= '0;
        for (int l = 0; l < LANES; l++) ps_r[k][l] <= '0;
      end
    end else begin
      st_r <= st_nxt; warm_r <= warm_nxt; lane_r <= lane_nxt;
      term_r <= term_nxt; acc_r <= acc_nxt; out_v_r <= out_v_nxt;
      if (st_r == S_OUT) begin
        // history shift once the request is done
        pt_r[2] <= pt_r[1]; pt_r[1] <= pt_r[0]; pt_r[0] <= t_r;
        for (int l = 0; l < LANES; l++) begin
          ps_r[2][l] <= ps_r[1][l]; ps_r[1][l] <= ps_r[0][l]; ps_r[0][l] <= v_r[l];
        end
      end
    end
    neg_r <= neg_nxt; num_r <= num_nxt;
    if (accept) begin
      t_r <= in_tdata[31:0];
      for (int l = 0; l < LANES; l++) begin
        v_r[l]   <= in_tdata[32*(l+1) +: 32];
        res_r[l] <= '0;
      end
      ready_flag_r <= (warm_r == 2'd3);
    end
    if (st_r == S_NEXT && term_r == 3'd4) res_r[lane_r] <= sat;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {res_r[2], res_r[1], res_r[0]};
  assign out_tuser  = ready_flag_r;
endmodule

// ----- verif/second_derivative_backward_diff_test.sv -----
// testbench for the backward-difference second derivative estimator
`timescale 1ns / 1ps

module second_derivative_backward_diff_test;
  import sdbd_pkg::*;

  localparam longint RUN_LIMIT = 30_000_000;  // cycles
  localparam int     DRAIN_CYCLES = 2500;     // wait after draining, before the final check

  typedef struct {
    logic signed [OUT_BITS-1:0] deriv [LANES];
    logic                       ready;
  } estimate_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // sample_time, value_x, value_y, value_z
  logic         out_tvalid;
  logic         out_tready;
  logic [143:0] out_tdata;  // deriv_x, deriv_y, deriv_z
  logic         out_tuser;  // estimate_ready

  second_derivative_backward_diff u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // predictor copy of the history
  logic [1:0]              seen_count;
  logic [TIME_BITS-1:0]    hist_time   [3];
  logic [SAMPLE_BITS-1:0]  hist_sample [3][LANES];

  estimate_t pending_estimates [$];
  int        error_count;
  int        requests_sent;
  int        estimates_checked;
  int        ready_estimates;
  int        saturated_estimates;
  int        sender_idle_pct;
  int        receiver_stall_pct;
  int        hold_cycles;
  longint    cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // one weighted term: 2*num*v / (f1*f2*f3), truncated toward zero, zero when
  // the denominator vanishes (repeated timestamps)
  function automatic logic signed [199:0] weighted_term(longint num, longint v,
      longint f1, longint f2, longint f3, bit minus);
    logic signed [199:0] den;
    logic signed [199:0] numer;
    logic signed [199:0] quo;
    den = f1;
    den = den * f2;
    den = den * f3;
    if (den == 0) return '0;
    numer = num;
    numer = numer * 2 * v;
    quo = numer / den;
    return minus ? -quo : quo;
  endfunction

  function automatic estimate_t predict_estimate(logic [127:0] data);
    estimate_t           res;
    logic [TIME_BITS-1:0] t;
    logic [TIME_BITS-1:0] diff;
    longint              d1, d2, d3, v, p1, p2, p3;
    logic signed [199:0] acc;
    t = data[31:0];
    if (seen_count < 2'd3) begin
      seen_count = seen_count + 2'd1;
      for (int l = 0; l < LANES; l++) res.deriv[l] = '0;
      res.ready = 1'b0;
    end else begin
      // time differences wrap modulo 2^32 and stay unsigned
      diff = t - hist_time[0]; d1 = longint'(diff);
      diff = t - hist_time[1]; d2 = longint'(diff);
      diff = t - hist_time[2]; d3 = longint'(diff);
      for (int l = 0; l < LANES; l++) begin
        v  = longint'($signed(data[32 + 32*l +: 32]));
        p1 = longint'($signed(hist_sample[0][l]));
        p2 = longint'($signed(hist_sample[1][l]));
        p3 = longint'($signed(hist_sample[2][l]));
        acc = weighted_term(d2 + d3, v,  d1, d2,      d3 - d1, 1'b0)
            + weighted_term(d1 + d2, v,  d2, d3,      d3 - d1, 1'b1)
            + weighted_term(d2 + d3, p1, d1, d1 - d2, d3 - d1, 1'b0)
            + weighted_term(d1 + d3, p2, d2, d1 - d2, d2 - d3, 1'b0)
            + weighted_term(d1 + d2, p3, d3, d2 - d3, d3 - d1, 1'b0);
        // clamp to the 48 bit signed range
        if (acc > 200'sd140737488355327)       res.deriv[l] = 48'sh7FFF_FFFF_FFFF;
        else if (acc < -200'sd140737488355328) res.deriv[l] = 48'sh8000_0000_0000;
        else                                   res.deriv[l] = acc[47:0];
      end
      res.ready = 1'b1;
    end
    hist_time[2] = hist_time[1];
    hist_time[1] = hist_time[0];
    hist_time[0] = t;
    for (int l = 0; l < LANES; l++) begin
      hist_sample[2][l] = hist_sample[1][l];
      hist_sample[1][l] = hist_sample[0][l];
      hist_sample[0][l] = data[32 + 32*l +: 32];
    end
    return res;
  endfunction

  // every accepted request gets its expected estimate queued
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      pending_estimates.push_back(predict_estimate(in_tdata));
      requests_sent++;
    end
  end

  // every accepted result is checked against the oldest expectation
  always @(posedge clk) begin
    estimate_t want;
    if (rst_n && out_tvalid && out_tready) begin
      estimates_checked++;
      if (pending_estimates.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = pending_estimates.pop_front();
        for (int l = 0; l < LANES; l++) begin
          if ($signed(out_tdata[48*l +: 48]) != want.deriv[l])
            report_mismatch($sformatf("lane %0d deriv got %0d want %0d", l,
                                      $signed(out_tdata[48*l +: 48]), want.deriv[l]));
          if (want.deriv[l] == 48'sh7FFF_FFFF_FFFF || want.deriv[l] == 48'sh8000_0000_0000)
            saturated_estimates++;
        end
        if (out_tuser !== want.ready)
          report_mismatch($sformatf("estimate_ready got %b want %b", out_tuser, want.ready));
        if (want.ready) ready_estimates++;
      end
    end
  end

  // receiver: random stalls, plus a counted long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_tready  <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // offer one request, hold it until taken, then maybe go idle
  task automatic send_request(input logic [31:0] t, input logic [31:0] vx,
                              input logic [31:0] vy, input logic [31:0] vz);
    in_tvalid <= 1'b1;
    in_tdata  <= {vz, vy, vx, t};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_sample();
    case ($urandom_range(5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(2047) - 1024;
      default: return $urandom;
    endcase
  endfunction

  // warm-up: first three requests answer zero, not ready
  task automatic test_warmup();
    send_request(32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(32'd101, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000);
    send_request(32'd103, 32'h0002_0000, 32'h0000_0001, 32'h8000_0000);
    send_request(32'd106, 32'h0004_0000, 32'h0000_0002, 32'h7FFF_FFFF);
  endtask

  // extreme samples over the tightest grid: largest weights and magnitudes
  task automatic test_extremes();
    send_request(32'd107, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(32'd108, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(32'd109, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    send_request(32'd110, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFF0, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
  endtask

  // repeated timestamps: vanishing denominators drop their terms
  task automatic test_zero_denominator();
    send_request(32'd5000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_request(32'd5000, 32'h0004_0000, 32'hFFFF_0000, 32'h1234_5678);
    send_request(32'd5004, 32'h0005_0000, 32'h0000_0010, 32'h8765_4321);
    send_request(32'd5004, 32'h0006_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(32'd5004, 32'h0007_0000, 32'h0000_0000, 32'h0000_0001);
    send_request(32'd5004, 32'h0008_0000, 32'h0000_0000, 32'h0000_0001);
  endtask

  // timestamps rolling over 2^32 and huge spacings
  task automatic test_time_wrap();
    send_request(32'hFFFF_FFFD, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_request(32'hFFFF_FFFF, 32'h0004_0000, 32'h0002_0000, 32'hFFFF_0000);
    send_request(32'h0000_0002, 32'h0009_0000, 32'h0003_0000, 32'hFFFE_0000);
    send_request(32'h0000_0006, 32'h0010_0000, 32'h0004_0000, 32'hFFFD_0000);
    send_request(32'h8000_0006, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    send_request(32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
  endtask

  // mostly monotonic sampling with random content, some noise and repeats
  task automatic test_random_stream(input int count);
    logic [31:0] t;
    t = $urandom;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0:       t = $urandom;                 // jump anywhere
        1:       t = t;                        // repeated timestamp
        2:       t = t + $urandom;             // large step, may wrap
        3:       t = t - $urandom_range(50);   // backward step
        default: t = t + $urandom_range(1, 64);
      endcase
      send_request(t, random_sample(), random_sample(), random_sample());
    end
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    hold_cycles <= 6000;
    test_random_stream(6);
  endtask

  initial begin
    rst_n              = 1'b0;
    in_tvalid          = 1'b0;
    in_tdata           = '0;
    error_count        = 0;
    requests_sent      = 0;
    estimates_checked  = 0;
    ready_estimates    = 0;
    saturated_estimates = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_cycles        = 0;
    cycle_count        = 0;
    seen_count         = '0;
    for (int k = 0; k < 3; k++) begin
      hist_time[k] = '0;
      for (int l = 0; l < LANES; l++) hist_sample[k][l] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_warmup();
    test_extremes();
    test_zero_denominator();
    test_time_wrap();

    // random traffic through the idle and stall mixes
    test_random_stream(430);
    sender_idle_pct = 51;
    test_random_stream(430);
    sender_idle_pct = 0;
    receiver_stall_pct = 51;
    test_random_stream(430);
    sender_idle_pct = 26;
    receiver_stall_pct = 26;
    test_random_stream(430);
    test_backpressure();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_estimates.size() != 0)
      report_mismatch($sformatf("%0d estimates never arrived", pending_estimates.size()));

    $display("covered warm-up, extremes, repeated and wrapping timestamps, long hold-off");
    $display("%0d requests, %0d checked, %0d ready, %0d saturated lanes",
             requests_sent, estimates_checked, ready_estimates, saturated_estimates);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
